// ----- rtl/rlma_pkg.sv -----
// shared constants and types of the run-length matrix accumulator
package rlma_pkg;

    localparam int LEVELS_DEF   = 16;
    localparam int RUN_BINS_DEF = 8;
    localparam int MAX_RUN_DEF  = 63;

    localparam int ACTION_W = 2;
    localparam int LEVEL_W  = 4;
    localparam int INDEX_W  = 6;
    localparam int BIN_W    = 3;
    localparam int COUNT_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_MAP_WR = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

endpackage

// ----- rtl/run_length_matrix_accumulator_unit.sv -----
// run-length matrix accumulator: top level with run tracking and counter update sequencer
//
// Accumulates a gray-level run-length matrix of RUN_BINS x LEVELS 16-bit
// counters from a stream of sample words, each carrying a quantized level and
// a last-in-line mark. Every accepted word gives exactly one result word. The
// run bin of a closed run comes from a loadable map memory (MAX_RUN+1 entries,
// content undefined until written), and the counters live in a second memory
// whose entries carry one valid flop each, so a clear resets them all at once
// and needs no sweep after reset. A new word is accepted only once the previous
// one has loaded its result word. Each closed run is done as the chain map
// read, counter read, counter write through the two memories with registered
// read data; a last-in-line sample that changes level closes two runs, handled
// one after the other. A stalled result port holds the result back. Each run
// close finishes its write before the next read starts, so no forwarding path
// is needed.
module run_length_matrix_accumulator_unit #(
    parameter int LEVELS   = rlma_pkg::LEVELS_DEF,
    parameter int RUN_BINS = rlma_pkg::RUN_BINS_DEF,
    parameter int MAX_RUN  = rlma_pkg::MAX_RUN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rlma_pkg::ACTION_W-1:0]  s_action,
    input  logic [rlma_pkg::LEVEL_W-1:0]   s_level,
    input  logic                           s_last_in_line,
    input  logic [rlma_pkg::INDEX_W-1:0]   s_map_index,
    input  logic [rlma_pkg::BIN_W-1:0]     s_run_bin,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rlma_pkg::COUNT_W-1:0]   m_count,
    output logic                           m_saturated
);

    import rlma_pkg::*;

    localparam int CNT_DEPTH = RUN_BINS * LEVELS;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int MAP_DEPTH = MAX_RUN + 1;
    localparam int RL_W      = $clog2(MAP_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_RD,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_RD_DATA,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // run in progress
    logic [LEVEL_W-1:0] prev_level_reg;
    logic [RL_W-1:0]    run_len_reg;
    logic               run_open_reg;

    // pending run closes: job 0 runs first, job 1 follows when two_jobs is set
    logic [RL_W-1:0]    job0_len_reg, job1_len_reg;
    logic [LEVEL_W-1:0] job0_lvl_reg, job1_lvl_reg;
    logic               two_jobs_reg;

    logic [CNT_AW-1:0]  wr_addr_reg;
    logic               rd_oob_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_sat_reg;

    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_sat_reg;

    // counter valid bits, cleared together; vld_q_reg lines up with ram read data
    logic [CNT_DEPTH-1:0] cnt_vld_reg;
    logic                 vld_q_reg;

    logic               accept;
    action_t            act;

    // sample decode
    logic [LEVEL_W-1:0] lvl_c;
    logic               open_same;
    logic               close_old;
    logic [RL_W-1:0]    new_len;

    // memory ports
    logic               map_we;
    logic [RL_W-1:0]    map_waddr;
    logic [BIN_W-1:0]   map_rdata;
    logic [BIN_W-1:0]   bin_c;
    logic [CNT_AW-1:0]  rd_addr_direct;
    logic [CNT_AW-1:0]  job_cnt_addr;
    logic [CNT_AW-1:0]  cnt_raddr;
    logic [COUNT_W-1:0] cnt_rdata;
    logic [COUNT_W-1:0] cnt_cur;
    logic               cnt_we;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign act     = action_t'(s_action);

    // levels past the top collapse onto the last column
    assign lvl_c = (32'(s_level) >= LEVELS) ? LEVEL_W'(LEVELS - 1) : s_level;

    assign open_same = run_open_reg && (lvl_c == prev_level_reg);
    assign close_old = run_open_reg && !open_same;
    always_comb begin
        if (!open_same) begin
            new_len = RL_W'(1);
        end else if (32'(run_len_reg) < MAX_RUN) begin
            new_len = run_len_reg + RL_W'(1);
        end else begin
            new_len = run_len_reg;
        end
    end

    // map writes beyond the longest run length are dropped
    assign map_we    = accept && (act == ACT_MAP_WR) && (32'(s_map_index) <= MAX_RUN);
    assign map_waddr = RL_W'(s_map_index);

    rlma_ram #(
        .WIDTH (BIN_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (s_run_bin),
        .raddr (job0_len_reg),
        .rdata (map_rdata)
    );

    // bins past the top collapse onto the last row
    assign bin_c = (32'(map_rdata) >= RUN_BINS) ? BIN_W'(RUN_BINS - 1) : map_rdata;
    assign job_cnt_addr   = CNT_AW'(32'(bin_c) * LEVELS + 32'(job0_lvl_reg));
    assign rd_addr_direct = CNT_AW'(32'(s_run_bin) * LEVELS + 32'(s_level));
    assign cnt_raddr      = (state_reg == ST_IDLE) ? rd_addr_direct : job_cnt_addr;

    // never-written counters read as zero
    assign cnt_cur   = vld_q_reg ? cnt_rdata : '0;
    assign cnt_we    = (state_reg == ST_CNT_WR) && (cnt_cur != COUNT_MAX);
    assign cnt_wdata = cnt_cur + COUNT_W'(1);

    rlma_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (wr_addr_reg),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_level_reg <= '0;
            run_len_reg    <= '0;
            run_open_reg   <= 1'b0;
            two_jobs_reg   <= 1'b0;
            cnt_vld_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            vld_q_reg <= cnt_vld_reg[cnt_raddr];
            // a taken result frees the output register unless a new one loads now
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_count_reg <= '0;
                        res_sat_reg   <= 1'b0;
                        unique case (act)
                            ACT_SAMPLE: begin
                                prev_level_reg <= lvl_c;
                                if (s_last_in_line) begin
                                    run_open_reg <= 1'b0;
                                    run_len_reg  <= '0;
                                end else begin
                                    run_open_reg <= 1'b1;
                                    run_len_reg  <= new_len;
                                end
                                // old run first, then the run the last sample ends
                                if (close_old) begin
                                    job0_len_reg <= run_len_reg;
                                    job0_lvl_reg <= prev_level_reg;
                                    job1_len_reg <= new_len;
                                    job1_lvl_reg <= lvl_c;
                                    two_jobs_reg <= s_last_in_line;
                                end else begin
                                    job0_len_reg <= new_len;
                                    job0_lvl_reg <= lvl_c;
                                    two_jobs_reg <= 1'b0;
                                end
                                state_reg <= (close_old || s_last_in_line) ? ST_MAP_RD
                                                                           : ST_FINISH;
                            end
                            ACT_MAP_WR: begin
                                state_reg <= ST_FINISH;
                            end
                            ACT_CLEAR: begin
                                cnt_vld_reg <= '0;
                                state_reg   <= ST_FINISH;
                            end
                            ACT_READ: begin
                                rd_oob_reg <= (32'(s_run_bin) >= RUN_BINS) ||
                                              (32'(s_level) >= LEVELS);
                                state_reg  <= ST_RD_DATA;
                            end
                            default: begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_MAP_RD: begin
                    state_reg <= ST_CNT_RD;
                end
                ST_CNT_RD: begin
                    wr_addr_reg <= job_cnt_addr;
                    state_reg   <= ST_CNT_WR;
                end
                ST_CNT_WR: begin
                    if (cnt_cur == COUNT_MAX) begin
                        res_sat_reg <= 1'b1;
                    end else begin
                        cnt_vld_reg[wr_addr_reg] <= 1'b1;
                    end
                    if (two_jobs_reg) begin
                        job0_len_reg <= job1_len_reg;
                        job0_lvl_reg <= job1_lvl_reg;
                        two_jobs_reg <= 1'b0;
                        state_reg    <= ST_MAP_RD;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_RD_DATA: begin
                    res_count_reg <= rd_oob_reg ? '0 : cnt_cur;
                    state_reg     <= ST_FINISH;
                end
                ST_FINISH: begin
                    // wait for the result register to free up
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_count_reg <= res_count_reg;
                        m_sat_reg   <= res_sat_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_count     = m_count_reg;
    assign m_saturated = m_sat_reg;

    // a run length is held exactly while a run is open
    a_run_len_open: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg == (run_len_reg != '0))
        else $error("run length and open flag disagree");

    // a counter read goes straight to its data cycle
    a_read_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (act == ACT_READ)) |=> (state_reg == ST_RD_DATA))
        else $error("counter read did not reach its data cycle");

    // counter writes only come from the update cycle of a closed run
    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> ($past(state_reg) == ST_CNT_RD))
        else $error("counter write outside a run close");

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_count_reg)))
        else $error("pending result overwritten");

endmodule

// ----- rtl/rlma_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module rlma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- bench/tb.sv -----
// self-checking testbench of the run-length matrix accumulator
`timescale 1ns / 1ps

module tb;
    import rlma_pkg::*;

    // no-progress limit, well above any correct stretch without a handshake
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_CAP     = 40;
    localparam int SLOTS          = RUN_BINS_DEF * LEVELS_DEF;

    // ways of filling the run-bin map
    typedef enum int {
        MAP_ZERO,
        MAP_ALL_TOP,
        MAP_LINEAR,
        MAP_RANDOM
    } map_fill_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               saturated;
    } result_word_t;

    // clock, reset and block ports; the driven inputs are known from time zero
    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action       = ACT_SAMPLE;
    logic [LEVEL_W-1:0]  s_level        = '0;
    logic                s_last_in_line = 1'b0;
    logic [INDEX_W-1:0]  s_map_index    = '0;
    logic [BIN_W-1:0]    s_run_bin      = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [COUNT_W-1:0]  m_count;
    logic                m_saturated;

    // predictor state: run in progress, bin map and the matrix itself
    logic [LEVEL_W-1:0]  run_level;
    logic [INDEX_W-1:0]  run_length;
    logic                run_active;
    logic [BIN_W-1:0]    bin_map [MAX_RUN_DEF+1];
    logic [COUNT_W-1:0]  glrlm [SLOTS];

    result_word_t        expected_words [$];
    result_word_t        want_word;

    // bookkeeping
    bit                  idle_on        = 1'b1;
    int                  mismatches     = 0;
    int                  words_sent     = 0;
    int                  results_checked = 0;
    int                  runs_closed    = 0;
    int                  runs_saturated = 0;
    int                  reads_sent     = 0;
    int                  clears_sent    = 0;
    int                  stall_left     = 0;
    int                  quiet_cycles   = 0;

    always #10 aclk = ~aclk;

    run_length_matrix_accumulator_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_level        (s_level),
        .s_last_in_line (s_last_in_line),
        .s_map_index    (s_map_index),
        .s_run_bin      (s_run_bin),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_count        (m_count),
        .m_saturated    (m_saturated)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // closes the run in progress into its matrix slot; 1 when the increment is lost
    function automatic bit close_open_run();
        logic [BIN_W+LEVEL_W-1:0] slot;
        slot = {bin_map[run_length], run_level};
        runs_closed++;
        if (glrlm[slot] == COUNT_MAX) begin
            runs_saturated++;
            return 1'b1;
        end
        glrlm[slot] = glrlm[slot] + 1'b1;
        return 1'b0;
    endfunction

    // updates the matrix model for one accepted word and queues the result word it owes
    function automatic void accumulate_word(action_t act, logic [LEVEL_W-1:0] lvl, logic last,
                                            logic [INDEX_W-1:0] idx, logic [BIN_W-1:0] bin);
        result_word_t res;
        res = '0;
        case (act)
            ACT_SAMPLE: begin
                if (run_active && lvl == run_level) begin
                    // same level: the run grows, stopping at the longest length
                    if (run_length < INDEX_W'(MAX_RUN_DEF)) run_length = run_length + 1'b1;
                end else begin
                    // level change closes the old run and opens a new one
                    if (run_active && close_open_run()) res.saturated = 1'b1;
                    run_level  = lvl;
                    run_length = INDEX_W'(1);
                    run_active = 1'b1;
                end
                // end of line flushes whatever is open, possibly a second close
                if (last) begin
                    if (close_open_run()) res.saturated = 1'b1;
                    run_active = 1'b0;
                    run_length = '0;
                end
            end
            ACT_MAP_WR: bin_map[idx] = bin;
            ACT_CLEAR: begin
                // counters only, the open run survives
                for (int i = 0; i < SLOTS; i++) glrlm[i] = '0;
            end
            default: res.count = glrlm[{bin, lvl}];
        endcase
        expected_words.push_back(res);
    endfunction

    // one word on the input channel; valid is only dropped for a gap before the word
    task automatic send_word(action_t act, logic [LEVEL_W-1:0] lvl, logic last,
                             logic [INDEX_W-1:0] idx, logic [BIN_W-1:0] bin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_level        <= lvl;
        s_last_in_line <= last;
        s_map_index    <= idx;
        s_run_bin      <= bin;
        do @(posedge aclk); while (!s_ready);
        accumulate_word(act, lvl, last, idx, bin);
        words_sent++;
    endtask

    // wrappers fill the fields an action ignores with random bits
    task automatic send_sample(logic [LEVEL_W-1:0] lvl, logic last);
        send_word(ACT_SAMPLE, lvl, last, INDEX_W'($urandom), BIN_W'($urandom));
    endtask

    task automatic send_map(logic [INDEX_W-1:0] idx, logic [BIN_W-1:0] bin);
        send_word(ACT_MAP_WR, LEVEL_W'($urandom), 1'($urandom), idx, bin);
    endtask

    task automatic send_read(logic [BIN_W-1:0] row, logic [LEVEL_W-1:0] col);
        send_word(ACT_READ, col, 1'($urandom), INDEX_W'($urandom), row);
        reads_sent++;
    endtask

    task automatic send_clear();
        send_word(ACT_CLEAR, LEVEL_W'($urandom), 1'($urandom), INDEX_W'($urandom),
                  BIN_W'($urandom));
        clears_sent++;
    endtask

    // sender holds off until every result word is back, then lets the pipe settle
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // writes every map entry, so no run ever looks up an unwritten length
    task automatic load_bin_map(map_fill_t fill);
        logic [BIN_W-1:0] bin;
        for (int i = 0; i <= MAX_RUN_DEF; i++) begin
            case (fill)
                MAP_ZERO:    bin = '0;
                MAP_ALL_TOP: bin = '1;
                MAP_LINEAR:  bin = BIN_W'(i >> (INDEX_W - BIN_W));
                default:     bin = BIN_W'($urandom);
            endcase
            send_map(INDEX_W'(i), bin);
        end
    endtask

    task automatic read_level_column(logic [LEVEL_W-1:0] col);
        for (int r = 0; r < RUN_BINS_DEF; r++) send_read(BIN_W'(r), col);
    endtask

    // short runs, level changes, single-sample lines and change on the last sample
    task automatic test_run_basics();
        load_bin_map(MAP_RANDOM);
        send_sample(4'd0, 1'b0);
        send_sample(4'd0, 1'b0);
        send_sample(4'd15, 1'b0);  // closes a run of two at level 0
        send_sample(4'd15, 1'b1);  // line end closes a run of two at level 15
        send_sample(4'd5, 1'b1);   // line of one sample
        send_sample(4'd5, 1'b0);
        send_sample(4'd9, 1'b1);   // change and end together: two runs close
        send_map(6'd63, 3'd7);
        send_map(6'd0, 3'd0);
        send_read(bin_map[1], 4'd9);
        send_read(bin_map[2], 4'd0);
        send_read(bin_map[2], 4'd15);
        send_read(bin_map[1], 4'd5);
        send_read(3'd7, 4'd15);
        send_read(3'd0, 4'd0);
        wait_results_drained();
    endtask

    // runs right at, below and past the longest tracked length
    task automatic test_long_runs();
        load_bin_map(MAP_LINEAR);
        send_map(6'd62, 3'd2);
        send_map(6'd63, 3'd5);
        repeat (61) send_sample(4'd6, 1'b0);
        send_sample(4'd6, 1'b1);   // 62
        repeat (62) send_sample(4'd6, 1'b0);
        send_sample(4'd6, 1'b1);   // 63
        repeat (69) send_sample(4'd6, 1'b0);
        send_sample(4'd6, 1'b1);   // 70, counted as 63
        read_level_column(4'd6);
        wait_results_drained();
    endtask

    // a clear in the middle of a run wipes the counters but not the run
    task automatic test_clear_keeps_run();
        send_sample(4'd3, 1'b0);
        send_sample(4'd3, 1'b0);
        send_clear();
        send_sample(4'd3, 1'b1);
        read_level_column(4'd3);
        send_sample(4'd10, 1'b0);
        send_clear();
        send_sample(4'd12, 1'b1);
        read_level_column(4'd10);
        wait_results_drained();
    endtask

    // one scan line built from runs of random level and length
    task automatic send_scan_line();
        int remaining;
        int run;
        logic [LEVEL_W-1:0] lvl;
        bit broken;
        remaining = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
        broken = ($urandom_range(0, 19) == 0);
        while (remaining > 0) begin
            lvl = LEVEL_W'($urandom);
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 4);
            if (run > remaining) run = remaining;
            repeat (run) begin
                remaining--;
                if ($urandom_range(0, 29) == 0) begin
                    // unrelated word in the middle of a line
                    if ($urandom_range(0, 1) == 0) send_read(BIN_W'($urandom), LEVEL_W'($urandom));
                    else send_map(INDEX_W'($urandom), BIN_W'($urandom));
                end
                if (broken) send_sample(lvl, ($urandom_range(0, 9) == 0));
                else send_sample(lvl, (remaining == 0));
            end
        end
    endtask

    // mostly well-formed lines, with map rewrites, reads, clears and loose samples mixed in
    task automatic test_random_traffic();
        map_fill_t fills [4];
        int stop_at;
        int next_switch;
        int r;
        fills = '{MAP_RANDOM, MAP_ZERO, MAP_ALL_TOP, MAP_RANDOM};
        for (int epoch = 0; epoch < 4; epoch++) begin
            load_bin_map(fills[epoch]);
            stop_at = words_sent + 100;
            next_switch = words_sent + 50;
            while (words_sent < stop_at) begin
                if (words_sent >= next_switch) begin
                    idle_on = ($urandom_range(0, 3) != 0);
                    next_switch = words_sent + 50;
                end
                r = $urandom_range(0, 99);
                if (r < 75) send_scan_line();
                else if (r < 83) send_sample(LEVEL_W'($urandom), 1'($urandom));
                else if (r < 88) send_map(INDEX_W'($urandom), BIN_W'($urandom));
                else if (r < 98) send_read(BIN_W'($urandom), LEVEL_W'($urandom));
                else send_clear();
            end
            idle_on = 1'b1;
            wait_results_drained();
        end
    endtask

    // one line per mismatch, capped so a broken block cannot flood the log
    task automatic report_mismatch(string what, logic [COUNT_W-1:0] got, logic [COUNT_W-1:0] want);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    endtask

    // result side stalls at random
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // every result word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected", m_count, '0);
            end else begin
                want_word = expected_words.pop_front();
                if (m_count !== want_word.count)
                    report_mismatch("count", m_count, want_word.count);
                if (m_saturated !== want_word.saturated)
                    report_mismatch("saturated", COUNT_W'(m_saturated),
                                    COUNT_W'(want_word.saturated));
            end
            results_checked++;
        end
    end

    // ends a hung run: too many cycles without a word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_words.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        // run and counter model match the block's reset state; the map model starts at zero
        run_level  = '0;
        run_length = '0;
        run_active = 1'b0;
        for (int i = 0; i < SLOTS; i++) glrlm[i] = '0;
        for (int i = 0; i <= MAX_RUN_DEF; i++) bin_map[i] = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_run_basics();
        test_long_runs();
        test_clear_keeps_run();
        test_random_traffic();

        // last words out, then a quiet stretch to catch stray results
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d words (%0d reads, %0d clears), checked %0d results",
                 words_sent, reads_sent, clears_sent, results_checked);
        $display("closed %0d runs, %0d of them lost to saturated counters, %0d mismatches",
                 runs_closed, runs_saturated, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
